// ===== sv/fjs_pkg.sv =====
`default_nettype none
package fjs_pkg;

    // geometry default
    localparam int WORDS_PER_PAGE_DEF = 16;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_RECOV  = 2'd2;
    localparam logic [1:0] OP_INJECT = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOVAL = 2'd1;
    localparam logic [1:0] STAT_CRASH = 2'd2;
    localparam logic [1:0] STAT_PERR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TWO_PHASE = 2'd0;
    localparam logic [1:0] CFG_CMT_FIRST = 2'd1;
    localparam logic [1:0] CFG_SCAN_CMT  = 2'd2;
    localparam logic [1:0] CFG_ECC_TRAP  = 2'd3;

    // flash constants
    localparam logic [63:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] HDR_RECEIVE = 32'hA5A5_A5A5;
    localparam logic [31:0] HDR_ACTIVE  = 32'h5A5A_5A5A;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] data_word;
        logic        inject_page;
        logic [3:0]  inject_index;
        logic        inject_bad;
    } t_cmd;

    typedef struct packed {
        logic [63:0] stored_value;
        logic        value_valid;
        logic [1:0]  status;
        logic [31:0] sequence_res;
        logic        active_page;
        logic [2:0]  free_slot;
    } t_res;

    // one byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage
`default_nettype wire

// ===== sv/fjs_ram.sv =====
`default_nettype none
module fjs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/flash_journal_store_top.sv =====
`default_nettype none
// Journaled 64-bit value store on a two-page flash model. A command is taken
// when start is high and busy is low; busy stays high until the result strobe
// o_done, which holds the result for exactly one cycle and cannot be stalled.
// All flash traffic goes through one word-wide RAM (read, then check and
// program) and all record checks through one byte-per-cycle CRC unit. A
// write moves the held value, if any, to the other page when the page is
// full. A recover reads each slot in full (at most (WORDS_PER_PAGE-2)/2
// slots), skips a slot for a bad word when the ECC trap is set, and stops
// at an erased commit word; it mounts an empty store when no header is
// found.
module flash_journal_store_top #(
    parameter int WORDS_PER_PAGE = fjs_pkg::WORDS_PER_PAGE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fjs_pkg::t_cmd i_cmd,
    output logic               o_done,
    output fjs_pkg::t_res      o_res,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fjs_pkg::*;

    localparam int DEPTH   = 2 * WORDS_PER_PAGE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(WORDS_PER_PAGE);
    localparam int SLOTS   = (WORDS_PER_PAGE - 2) / 2;
    localparam int SLOT_CW = $clog2(SLOTS + 1);
    localparam int SLOT_W  = (SLOT_CW > 3) ? SLOT_CW : 3;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS);
    localparam logic [ADDR_W-1:0] PAGE_OFS = ADDR_W'(WORDS_PER_PAGE);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WCHK  = 5'd1;
    localparam logic [4:0] S_MVH0  = 5'd2;
    localparam logic [4:0] S_MVH1  = 5'd3;
    localparam logic [4:0] S_REC   = 5'd4;
    localparam logic [4:0] S_CRC   = 5'd5;
    localparam logic [4:0] S_PRD   = 5'd6;
    localparam logic [4:0] S_PWR   = 5'd7;
    localparam logic [4:0] S_HRD   = 5'd8;
    localparam logic [4:0] S_HCHK  = 5'd9;
    localparam logic [4:0] S_HEND  = 5'd10;
    localparam logic [4:0] S_MTH1  = 5'd11;
    localparam logic [4:0] S_LOOP  = 5'd12;
    localparam logic [4:0] S_SRD   = 5'd13;
    localparam logic [4:0] S_SCHK  = 5'd14;
    localparam logic [4:0] S_SCMP  = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    function automatic logic [ADDR_W-1:0] f_addr(input logic pg, input logic [IDX_W-1:0] idx);
        return pg ? (PAGE_OFS + ADDR_W'(idx)) : ADDR_W'(idx);
    endfunction

    function automatic logic [IDX_W-1:0] f_slot_idx(input logic [SLOT_W-1:0] s,
                                                    input logic odd);
        return IDX_W'(32'(s) * 2 + 2 + 32'(odd));
    endfunction

    logic [4:0]        r_state, n_state;
    logic [3:0]        r_cfg;
    logic              r_page, n_page;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [31:0]       r_rseq, n_rseq;
    logic [31:0]       r_pseq, n_pseq;
    logic [63:0]       r_hval, n_hval;
    logic              r_hvalid, n_hvalid;
    logic [DEPTH-1:0]  r_valid, n_valid;
    logic [DEPTH-1:0]  r_bad, n_bad;
    logic              r_fault, n_fault;
    logic [1:0]        r_status, n_status;
    logic [63:0]       r_din, n_din;
    logic [1:0]        r_op, n_op;
    logic              r_mv, n_mv;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_rv, n_rv;
    logic              r_rb, n_rb;
    logic              r_pg, n_pg;
    logic              r_have, n_have;
    logic [31:0]       r_best, n_best;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [SLOT_W-1:0] r_nxt, n_nxt;
    logic              r_ph, n_ph;
    logic              r_found, n_found;
    logic [31:0]       r_bseq, n_bseq;
    logic [63:0]       r_bval, n_bval;
    logic [63:0]       r_pay, n_pay;
    logic [63:0]       r_mark, n_mark;
    logic [31:0]       r_crc, n_crc;
    logic [95:0]       r_cdat, n_cdat;
    logic [3:0]        r_ccnt, n_ccnt;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [63:0]       ram_rdata;

    fjs_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_flash (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = {31'h0, r_cfg[paddr[3:2]]};

    // handshake and result
    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    always_comb begin
        o_res.stored_value = r_hval;
        o_res.value_valid  = r_hvalid;
        o_res.status       = r_status;
        o_res.sequence_res = r_rseq;
        o_res.active_page  = r_page;
        o_res.free_slot    = r_slot[2:0];
    end

    // sequencer
    always_comb begin
        logic [63:0] w;
        logic        is_cmt;
        logic [31:0] crc_nx;
        logic [63:0] rec_val;
        logic        prog_ok;

        n_state = r_state;  n_page = r_page;   n_slot = r_slot;   n_rseq = r_rseq;
        n_pseq = r_pseq;    n_hval = r_hval;   n_hvalid = r_hvalid;
        n_valid = r_valid;  n_bad = r_bad;     n_fault = r_fault; n_status = r_status;
        n_din = r_din;      n_op = r_op;       n_mv = r_mv;       n_addr = r_addr;
        n_rv = r_rv;        n_rb = r_rb;       n_pg = r_pg;       n_have = r_have;
        n_best = r_best;    n_s = r_s;         n_nxt = r_nxt;     n_ph = r_ph;
        n_found = r_found;  n_bseq = r_bseq;   n_bval = r_bval;   n_pay = r_pay;
        n_mark = r_mark;    n_crc = r_crc;     n_cdat = r_cdat;   n_ccnt = r_ccnt;
        ram_we = 1'b0;      ram_waddr = r_addr; ram_wdata = r_din; ram_raddr = r_addr;

        w       = r_rv ? ram_rdata : ERASED_WORD;
        crc_nx  = crc_byte(r_crc, r_cdat[7:0]);
        rec_val = r_mv ? r_hval : r_din;
        prog_ok = !r_rb && (!r_rv || ram_rdata == ERASED_WORD);
        is_cmt  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_din   = i_cmd.data_word;
                    n_op    = i_cmd.opcode;
                    n_fault = 1'b0;
                    case (i_cmd.opcode)
                        OP_WRITE: n_state = S_WCHK;
                        OP_READ: begin
                            n_status = r_hvalid ? STAT_OK : STAT_NOVAL;
                            n_state  = S_DONE;
                        end
                        OP_RECOV: begin
                            n_hvalid = 1'b0; n_rseq = '0; n_hval = '0;
                            n_page = 1'b0;   n_slot = '0; n_pseq = '0;
                            n_pg = 1'b0;     n_have = 1'b0; n_best = '0;
                            n_state = S_HRD;
                        end
                        default: begin
                            // raw inject, out-of-page indexes dropped
                            if (32'(i_cmd.inject_index) < 32'(WORDS_PER_PAGE)) begin
                                ram_we    = 1'b1;
                                ram_waddr = f_addr(i_cmd.inject_page,
                                                   IDX_W'(i_cmd.inject_index));
                                ram_wdata = i_cmd.data_word;
                                n_valid[ram_waddr] = 1'b1;
                                n_bad[ram_waddr]   = i_cmd.inject_bad;
                            end
                            n_status = STAT_OK;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            // page full: erase the other page and move there
            S_WCHK: begin
                if (r_slot >= SLOT_MAX) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if ((i >= WORDS_PER_PAGE) == !r_page) begin
                            n_valid[i] = 1'b0;
                            n_bad[i]   = 1'b0;
                        end
                    end
                    n_state = S_MVH0;
                end else begin
                    n_mv    = 1'b0;
                    n_state = S_REC;
                end
            end
            S_MVH0: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(!r_page, IDX_W'(0));
                ram_wdata = {HDR_RECEIVE, r_pseq + 32'd1};
                n_valid[ram_waddr] = 1'b1;
                n_state = S_MVH1;
            end
            S_MVH1: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(!r_page, IDX_W'(1));
                ram_wdata = {HDR_ACTIVE, r_pseq + 32'd1};
                n_valid[ram_waddr] = 1'b1;
                n_page  = !r_page;
                n_pseq  = r_pseq + 32'd1;
                n_slot  = '0;
                n_mv    = r_hvalid;
                n_state = S_REC;
            end

            // new record: sequence, then CRC
            S_REC: begin
                n_rseq  = r_rseq + 32'd1;
                n_cdat  = {r_rseq + 32'd1, rec_val};
                n_crc   = CRC_INIT;
                n_ccnt  = '0;
                n_state = S_CRC;
            end
            S_CRC: begin
                n_crc  = crc_nx;
                n_cdat = r_cdat >> 8;
                n_ccnt = r_ccnt + 4'd1;
                if (r_ccnt == 4'd11) begin
                    if (r_op == OP_RECOV) begin
                        n_state = S_SCMP;
                    end else begin
                        n_mark  = {r_rseq, ~crc_nx};
                        n_ph    = 1'b0;
                        n_state = S_PRD;
                    end
                end
            end

            // program one record word with the erased check
            S_PRD: begin
                ram_raddr = f_addr(r_page, f_slot_idx(r_slot, r_cfg[CFG_CMT_FIRST] ^ r_ph));
                n_addr  = ram_raddr;
                n_rv    = r_valid[ram_raddr];
                n_rb    = r_bad[ram_raddr];
                n_state = S_PWR;
            end
            S_PWR: begin
                is_cmt = r_cfg[CFG_CMT_FIRST] ^ r_ph;
                if (prog_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = is_cmt ? r_mark : rec_val;
                    n_valid[r_addr] = 1'b1;
                end else begin
                    n_fault = 1'b1;
                end
                if (!r_ph) begin
                    n_ph    = 1'b1;
                    n_state = S_PRD;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                    if (r_mv) begin
                        n_mv    = 1'b0;
                        n_state = S_REC;
                    end else begin
                        n_hvalid = 1'b1;
                        n_hval   = r_din;
                        n_status = (r_fault || !prog_ok) ? STAT_PERR : STAT_OK;
                        n_state  = S_DONE;
                    end
                end
            end

            // recover: header of each page
            S_HRD: begin
                ram_raddr = f_addr(r_pg, IDX_W'(r_cfg[CFG_TWO_PHASE]));
                n_rv    = r_valid[ram_raddr];
                n_rb    = r_bad[ram_raddr];
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (r_rb && !r_cfg[CFG_ECC_TRAP]) begin
                    n_status = STAT_CRASH;
                    n_state  = S_DONE;
                end else begin
                    if (!r_rb && w[63:32] == (r_cfg[CFG_TWO_PHASE] ? HDR_ACTIVE : HDR_RECEIVE)
                        && (!r_have || w[31:0] >= r_best)) begin
                        n_best = w[31:0];
                        n_page = r_pg;
                        n_have = 1'b1;
                    end
                    if (r_pg) begin
                        n_state = S_HEND;
                    end else begin
                        n_pg    = 1'b1;
                        n_state = S_HRD;
                    end
                end
            end
            S_HEND: begin
                if (!r_have) begin
                    // empty mount: fresh page 0 with both headers
                    for (int i = 0; i < WORDS_PER_PAGE; i++) begin
                        n_valid[i] = 1'b0;
                        n_bad[i]   = 1'b0;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = f_addr(1'b0, IDX_W'(0));
                    ram_wdata = {HDR_RECEIVE, 32'd1};
                    n_valid[ram_waddr] = 1'b1;
                    n_state = S_MTH1;
                end else begin
                    n_pseq  = r_best;
                    n_s     = '0;
                    n_nxt   = '0;
                    n_found = 1'b0;
                    n_state = S_LOOP;
                end
            end
            S_MTH1: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(1'b0, IDX_W'(1));
                ram_wdata = {HDR_ACTIVE, 32'd1};
                n_valid[ram_waddr] = 1'b1;
                n_pseq   = 32'd1;
                n_slot   = '0;
                n_status = STAT_NOVAL;
                n_state  = S_DONE;
            end

            // recover: slot scan
            S_LOOP: begin
                n_ph    = 1'b0;
                n_state = (r_s == SLOT_MAX) ? S_FIN : S_SRD;
            end
            S_SRD: begin
                ram_raddr = f_addr(r_page, f_slot_idx(r_s, r_cfg[CFG_SCAN_CMT] ^ r_ph));
                n_rv    = r_valid[ram_raddr];
                n_rb    = r_bad[ram_raddr];
                n_state = S_SCHK;
            end
            S_SCHK: begin
                is_cmt = r_cfg[CFG_SCAN_CMT] ^ r_ph;
                if (r_rb) begin
                    if (!r_cfg[CFG_ECC_TRAP]) begin
                        n_status = STAT_CRASH;
                        n_state  = S_DONE;
                    end else begin
                        n_nxt   = r_s + SLOT_W'(1);
                        n_s     = r_s + SLOT_W'(1);
                        n_state = S_LOOP;
                    end
                end else if (is_cmt && w == ERASED_WORD) begin
                    n_nxt   = r_s;
                    n_state = S_FIN;
                end else begin
                    if (is_cmt) begin
                        n_mark = w;
                    end else begin
                        n_pay = w;
                    end
                    if (!r_ph) begin
                        n_ph    = 1'b1;
                        n_state = S_SRD;
                    end else begin
                        n_nxt   = r_s + SLOT_W'(1);
                        n_cdat  = {is_cmt ? w[63:32] : r_mark[63:32], is_cmt ? r_pay : w};
                        n_crc   = CRC_INIT;
                        n_ccnt  = '0;
                        n_state = S_CRC;
                    end
                end
            end
            S_SCMP: begin
                if (r_mark[31:0] == ~r_crc && (!r_found || r_mark[63:32] >= r_bseq)) begin
                    n_bseq  = r_mark[63:32];
                    n_bval  = r_pay;
                    n_found = 1'b1;
                end
                n_s     = r_s + SLOT_W'(1);
                n_state = S_LOOP;
            end
            S_FIN: begin
                if (r_found) begin
                    n_hvalid = 1'b1;
                    n_rseq   = r_bseq;
                    n_hval   = r_bval;
                end
                n_slot   = r_nxt;
                n_status = r_fault ? STAT_PERR : (r_found ? STAT_OK : STAT_NOVAL);
                n_state  = S_DONE;
            end

            S_DONE: n_state = S_IDLE;

            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 4'b1101;
            r_page   <= 1'b0;
            r_slot   <= '0;
            r_rseq   <= '0;
            r_pseq   <= '0;
            r_hval   <= '0;
            r_hvalid <= 1'b0;
            r_valid  <= '0;
            r_bad    <= '0;
        end else begin
            r_state  <= n_state;
            r_page   <= n_page;
            r_slot   <= n_slot;
            r_rseq   <= n_rseq;
            r_pseq   <= n_pseq;
            r_hval   <= n_hval;
            r_hvalid <= n_hvalid;
            r_valid  <= n_valid;
            r_bad    <= n_bad;
            if (cfg_wr) begin
                r_cfg[paddr[3:2]] <= pwdata[0];
            end
        end
        r_fault  <= n_fault;  r_status <= n_status; r_din   <= n_din;   r_op   <= n_op;
        r_mv     <= n_mv;     r_addr   <= n_addr;   r_rv    <= n_rv;    r_rb   <= n_rb;
        r_pg     <= n_pg;     r_have   <= n_have;   r_best  <= n_best;  r_s    <= n_s;
        r_nxt    <= n_nxt;    r_ph     <= n_ph;     r_found <= n_found; r_bseq <= n_bseq;
        r_bval   <= n_bval;   r_pay    <= n_pay;    r_mark  <= n_mark;  r_crc  <= n_crc;
        r_cdat   <= n_cdat;   r_ccnt   <= n_ccnt;
    end

endmodule
`default_nettype wire
